### rtl/b64se_pkg.sv
package b64se_pkg;

	// Output character codes outside the alphabet, and the reset value of the wrap limit.
	localparam logic [7:0] LINE_FEED  = 8'h0A;
	localparam logic [7:0] PAD_CHAR   = 8'h3D;
	localparam logic [7:0] WRAP_RESET = 8'd72;

	// A job holds every character caused by one input item.
	localparam int MAX_CHARS = 5;
	localparam int CNT_W     = 3;

	typedef struct packed {
		logic [MAX_CHARS-1:0][7:0] chars;
		logic [CNT_W-1:0]          count;
		logic                      done;
	} job_t;

	// Standard base64 alphabet lookup.
	function automatic logic [7:0] enc_sextet(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26) begin
			r = 8'h41 + {2'b00, v};
		end else if (v < 6'd52) begin
			r = 8'h61 + {2'b00, v - 6'd26};
		end else if (v < 6'd62) begin
			r = 8'h30 + {2'b00, v - 6'd52};
		end else if (v == 6'd62) begin
			r = 8'h2B;
		end else begin
			r = 8'h2F;
		end
		return r;
	endfunction

endpackage

### rtl/b64se_front.sv
module b64se_front
	import b64se_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [7:0] data_byte,
	input  logic       queue_full,
	output logic       push,
	output job_t       push_job
);

	logic [7:0] wrap_limit_q;
	logic [7:0] pend0_q;
	logic [7:0] pend1_q;
	logic [1:0] pend_cnt_q;
	logic [7:0] line_cnt_q;

	logic       accept;
	logic       produce;
	logic [8:0] cnt_sum;
	logic       wrap;
	job_t       job;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;
	assign cnt_sum  = {1'b0, line_cnt_q} + 9'd4;
	assign wrap     = cnt_sum >= {1'b0, wrap_limit_q};

	// Classify the beat and build the characters it causes.
	always_comb begin
		job     = '0;
		produce = 1'b0;
		if (!kind) begin
			job.chars[0] = enc_sextet(pend0_q[7:2]);
			job.chars[1] = enc_sextet({pend0_q[1:0], pend1_q[7:4]});
			job.chars[2] = enc_sextet({pend1_q[3:0], data_byte[7:6]});
			job.chars[3] = enc_sextet(data_byte[5:0]);
			job.chars[4] = LINE_FEED;
			job.count    = wrap ? CNT_W'(5) : CNT_W'(4);
			produce      = pend_cnt_q == 2'd2;
		end else begin
			job.done = 1'b1;
			case (pend_cnt_q)
				2'd0: begin
					job.chars[0] = LINE_FEED;
					job.count    = CNT_W'(1);
					produce      = line_cnt_q != 8'd0;
				end
				2'd1: begin
					job.chars[0] = enc_sextet(pend0_q[7:2]);
					job.chars[1] = enc_sextet({pend0_q[1:0], 4'b0000});
					job.chars[2] = PAD_CHAR;
					job.chars[3] = PAD_CHAR;
					job.chars[4] = LINE_FEED;
					job.count    = CNT_W'(5);
					produce      = 1'b1;
				end
				default: begin
					job.chars[0] = enc_sextet(pend0_q[7:2]);
					job.chars[1] = enc_sextet({pend0_q[1:0], pend1_q[7:4]});
					job.chars[2] = enc_sextet({pend1_q[3:0], 2'b00});
					job.chars[3] = PAD_CHAR;
					job.chars[4] = LINE_FEED;
					job.count    = CNT_W'(5);
					produce      = 1'b1;
				end
			endcase
		end
	end

	assign push     = accept && produce;
	assign push_job = job;

	// Pending bytes, line count and the wrap register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_limit_q <= WRAP_RESET;
			pend0_q      <= '0;
			pend1_q      <= '0;
			pend_cnt_q   <= '0;
			line_cnt_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				wrap_limit_q <= cfg_wr_data;
			end
			if (accept) begin
				if (kind) begin
					pend0_q    <= '0;
					pend1_q    <= '0;
					pend_cnt_q <= '0;
					line_cnt_q <= '0;
				end else if (pend_cnt_q == 2'd2) begin
					pend_cnt_q <= '0;
					line_cnt_q <= wrap ? 8'd0 : cnt_sum[7:0];
				end else begin
					if (pend_cnt_q[0]) begin
						pend1_q <= data_byte;
					end else begin
						pend0_q <= data_byte;
					end
					pend_cnt_q <= pend_cnt_q + 2'd1;
				end
			end
		end
	end

endmodule

### rtl/b64se_queue.sv
module b64se_queue
	import b64se_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int QCNT_W = $clog2(DEPTH + 1);

	job_t              mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = count_q == QCNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = mem_q[rd_ptr_q];

	// Job storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/b64se_back.sv
module b64se_back
	import b64se_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  job_t       head_job,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       last_of_run,
	output logic       message_done
);

	logic [CNT_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             last_q;
	logic             done_q;

	logic             load;
	logic             emit;
	logic             is_last;

	assign load    = !out_valid_q || !out_stall;
	assign emit    = load && head_valid;
	assign is_last = idx_q == head_job.count - CNT_W'(1);
	assign pop     = emit && is_last;

	// Character index within the head job.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				idx_q <= is_last ? '0 : idx_q + CNT_W'(1);
			end
			if (load) begin
				out_valid_q <= head_valid;
			end
		end
	end

	// Output beat register.
	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= head_job.chars[idx_q];
			last_q     <= is_last;
			done_q     <= is_last && head_job.done;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_char     = out_char_q;
	assign last_of_run  = last_q;
	assign message_done = done_q;

endmodule

### rtl/base64_stream_encoder_top.sv
// Line-wrapped base64 encoder. Input beats carry one message byte each (kind 0)
// or close the message (kind 1); every third byte yields four alphabet characters,
// a line feed follows once the line count reaches wrap_limit, and the end beat
// flushes any leftover bytes as a padded quad and ends a non-empty line with a line
// feed. An input beat is taken every cycle while the job queue between the front and
// back sides has room; the back side emits one character per cycle while out_stall
// is low. The job a beat causes is written into the queue, and its characters then
// leave through the output register.
// Write wrap_limit only while the block is idle.
module base64_stream_encoder_top
	import b64se_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       kind,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       last_of_run,
	output logic       message_done
);

	logic queue_full;
	logic push;
	job_t push_job;
	logic pop;
	logic head_valid;
	job_t head_job;

	b64se_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.data_byte   (data_byte),
		.queue_full  (queue_full),
		.push        (push),
		.push_job    (push_job)
	);

	b64se_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	b64se_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_job     (head_job),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_char     (out_char),
		.last_of_run  (last_of_run),
		.message_done (message_done)
	);

	// The end-of-message mark only sits on the closing beat of a run.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_done |-> last_of_run)
		else $error("message_done without last_of_run");

	// The queue is never written while full.
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !queue_full)
		else $error("job queue overflow");

	// The back side only retires a job that is present.
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("job queue underflow");

	// Every queued job holds between one and five characters.
	assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (head_job.count != '0) && (head_job.count <= CNT_W'(MAX_CHARS)))
		else $error("job with bad character count");

endmodule

### dv/base64_stream_encoder_top_test.sv
module base64_stream_encoder_top_test;
	import b64se_pkg::*;

	// Input beat kinds.
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Run limit in clock cycles, far above the slowest legal run.
	localparam int CYCLE_LIMIT = 600000;

	// Standard alphabet, first character in the top byte.
	localparam logic [8*64-1:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       done;
	} enc_char_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       kind = KIND_DATA;
	logic [7:0] data_byte = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_char;
	logic       last_of_run;
	logic       message_done;

	// Encoder state as predicted by the testbench.
	logic [7:0] model_wrap;
	logic [7:0] model_pend [2];
	logic [1:0] model_pend_cnt;
	logic [7:0] model_line;

	enc_char_t  enc_expect_q [$];
	enc_char_t  exp_c;
	int         err_count = 0;
	int         cycle_count = 0;
	int         beats_accepted = 0;
	bit         tx_gaps_on = 1'b1;
	bit         rx_gaps_on = 1'b1;
	int         rx_hold_left = 0;
	int         rx_gap_left = 0;

	base64_stream_encoder_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_char     (out_char),
		.last_of_run  (last_of_run),
		.message_done (message_done)
	);

	initial begin
		forever begin
			#2 clk = ~clk;
		end
	end

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		return B64_ALPHABET[8 * (63 - int'(v)) +: 8];
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 9);
		if (r < 8) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Predicts the characters one accepted beat causes and queues them.
	function automatic void encode_beat(input logic k, input logic [7:0] b);
		logic [7:0] chars [5];
		logic [8:0] cnt;
		logic [7:0] b0;
		logic [7:0] b1;
		int n;
		enc_char_t c;
		n = 0;
		b0 = model_pend[0];
		b1 = model_pend[1];
		if (k == KIND_DATA) begin
			if (model_pend_cnt < 2'd2) begin
				model_pend[model_pend_cnt[0]] = b;
				model_pend_cnt = model_pend_cnt + 2'd1;
				return;
			end
			chars[0] = sextet_char(b0[7:2]);
			chars[1] = sextet_char({b0[1:0], b1[7:4]});
			chars[2] = sextet_char({b1[3:0], b[7:6]});
			chars[3] = sextet_char(b[5:0]);
			n = 4;
			model_pend_cnt = 2'd0;
			cnt = {1'b0, model_line} + 9'd4;
			if (cnt >= {1'b0, model_wrap}) begin
				chars[4] = LINE_FEED;
				n = 5;
				cnt = 9'd0;
			end
			model_line = cnt[7:0];
		end else begin
			cnt = {1'b0, model_line};
			// Leftover bytes close with a padded quad; it never wraps by itself.
			if (model_pend_cnt != 2'd0) begin
				chars[0] = sextet_char(b0[7:2]);
				if (model_pend_cnt == 2'd1) begin
					chars[1] = sextet_char({b0[1:0], 4'h0});
					chars[2] = PAD_CHAR;
				end else begin
					chars[1] = sextet_char({b0[1:0], b1[7:4]});
					chars[2] = sextet_char({b1[3:0], 2'b00});
				end
				chars[3] = PAD_CHAR;
				n = 4;
				cnt = cnt + 9'd4;
			end
			if (cnt != 9'd0) begin
				chars[n] = LINE_FEED;
				n = n + 1;
			end
			model_pend[0] = 8'd0;
			model_pend[1] = 8'd0;
			model_pend_cnt = 2'd0;
			model_line = 8'd0;
		end
		for (int i = 0; i < n; i++) begin
			c.ch = chars[i];
			c.last = (i == n - 1);
			c.done = (i == n - 1) && (k == KIND_END);
			enc_expect_q.push_back(c);
		end
	endfunction

	// Offers one beat and returns at the edge that accepts it.
	task automatic send_beat(input logic k, input logic [7:0] b);
		int gap;
		gap = 0;
		if (tx_gaps_on && $urandom_range(0, 2) == 0) begin
			gap = pick_gap();
		end
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			kind <= logic'($urandom_range(0, 1));
			data_byte <= 8'($urandom_range(0, 255));
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= k;
		data_byte <= b;
		do begin
			@(posedge clk);
		end while (in_stall);
		encode_beat(k, b);
		beats_accepted++;
	endtask

	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) begin
			send_beat(KIND_DATA, 8'($urandom_range(0, 255)));
		end
		send_beat(KIND_END, 8'($urandom_range(0, 255)));
	endtask

	// Stops offering beats and waits until every expected character has come.
	task automatic drain_output();
		@(negedge clk);
		in_valid <= 1'b0;
		while (enc_expect_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_wrap(input logic [7:0] v);
		drain_output();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 8'($urandom_range(0, 255));
		model_wrap = v;
	endtask

	// Byte extremes, empty ends and both leftover cases at the reset limit.
	task automatic test_basic_groups();
		send_beat(KIND_END, 8'hFF);
		send_beat(KIND_DATA, 8'h00);
		send_beat(KIND_DATA, 8'h00);
		send_beat(KIND_DATA, 8'h00);
		send_beat(KIND_DATA, 8'hFF);
		send_beat(KIND_DATA, 8'hFF);
		send_beat(KIND_DATA, 8'hFF);
		send_beat(KIND_END, 8'h00);
		send_beat(KIND_DATA, 8'hFF);
		send_beat(KIND_END, 8'h00);
		send_beat(KIND_DATA, 8'h00);
		send_beat(KIND_DATA, 8'hFF);
		send_beat(KIND_END, 8'hFF);
		send_beat(KIND_END, 8'h00);
	endtask

	// At a limit of four every full quad is followed by a line feed.
	task automatic test_small_wrap();
		write_wrap(8'd4);
		send_beat(KIND_DATA, 8'hA5);
		send_beat(KIND_DATA, 8'h5A);
		send_beat(KIND_DATA, 8'hC3);
		send_beat(KIND_END, 8'h3C);
	endtask

	// A padded quad that reaches the limit gets only the closing line feed.
	task automatic test_pad_no_wrap();
		write_wrap(8'd8);
		send_beat(KIND_DATA, 8'h12);
		send_beat(KIND_DATA, 8'h34);
		send_beat(KIND_DATA, 8'h56);
		send_beat(KIND_DATA, 8'h78);
		send_beat(KIND_END, 8'h9A);
	endtask

	// The receiver holds off while the sender keeps offering beats.
	task automatic test_backpressure();
		write_wrap(WRAP_RESET);
		tx_gaps_on = 1'b0;
		rx_hold_left = 300;
		send_message(38);
		drain_output();
		tx_gaps_on = 1'b1;
	endtask

	// Random messages under several limits and idling mixes.
	task automatic test_random_messages();
		logic [7:0] limits [6];
		int start;
		int len;
		int r;
		limits[0] = WRAP_RESET;
		limits[1] = 8'd4;
		limits[2] = 8'd252;
		limits[3] = 8'd5;
		limits[4] = 8'($urandom_range(4, 252));
		limits[5] = 8'($urandom_range(4, 40));
		for (int p = 0; p < 6; p++) begin
			write_wrap(limits[p]);
			tx_gaps_on = (p % 3 != 1) && (p != 3);
			rx_gaps_on = (p % 3 != 2) && (p != 3);
			start = beats_accepted;
			while (beats_accepted - start < 22) begin
				r = $urandom_range(0, 19);
				if (r < 12) begin
					len = $urandom_range(0, 8);
				end else if (r < 18) begin
					len = $urandom_range(9, 40);
				end else begin
					len = $urandom_range(41, 80);
				end
				send_message(len);
			end
		end
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	// Receiver stall: a long hold when asked, otherwise random gaps.
	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold_left > 0) begin
				out_stall <= 1'b1;
				rx_hold_left--;
			end else if (rx_gap_left > 0) begin
				out_stall <= 1'b1;
				rx_gap_left--;
			end else begin
				out_stall <= 1'b0;
				if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
					rx_gap_left = pick_gap();
				end
			end
		end
	end

	// Each accepted output beat is checked against the oldest prediction.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (enc_expect_q.size() == 0) begin
					$error("unexpected output beat: out_char %h", out_char);
					err_count++;
				end else begin
					exp_c = enc_expect_q.pop_front();
					if (out_char !== exp_c.ch) begin
						$error("out_char: expected %h, got %h", exp_c.ch, out_char);
						err_count++;
					end
					if (last_of_run !== exp_c.last) begin
						$error("last_of_run: expected %b, got %b", exp_c.last, last_of_run);
						err_count++;
					end
					if (message_done !== exp_c.done) begin
						$error("message_done: expected %b, got %b", exp_c.done, message_done);
						err_count++;
					end
				end
			end
		end
	end

	// Watchdog on the total run length.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		model_wrap = WRAP_RESET;
		model_pend[0] = 8'd0;
		model_pend[1] = 8'd0;
		model_pend_cnt = 2'd0;
		model_line = 8'd0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_basic_groups();
		test_small_wrap();
		test_pad_no_wrap();
		test_backpressure();
		test_random_messages();
		drain_output();
		repeat (20) @(posedge clk);
		if (enc_expect_q.size() != 0) begin
			$error("%0d expected characters never arrived", enc_expect_q.size());
			err_count++;
		end
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/b64se_pkg.sv
rtl/b64se_front.sv
rtl/b64se_queue.sv
rtl/b64se_back.sv
rtl/base64_stream_encoder_top.sv
dv/base64_stream_encoder_top_test.sv
